### design/cesu8_pkg.sv
package cesu8_pkg;

    // Field widths of one transaction.
    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;
    localparam int unsigned UsedW = 3;

    // Byte patterns used while decoding.
    localparam logic [ByteW-1:0] SurrLead   = 8'hED;
    localparam logic [3:0]       SurrHiNib  = 4'hA;
    localparam logic [3:0]       SurrLoNib  = 4'hB;
    localparam logic [2:0]       TwoBytePfx = 3'b110;
    localparam logic [1:0]       ContPfx    = 2'b10;

    // Code point limits.
    localparam logic [CpW-1:0] SuppBase  = 21'h010000;
    localparam logic [CpW-1:0] CpMax     = 21'h10FFFF;
    localparam logic [CpW-1:0] SurrFirst = 21'h00D800;
    localparam logic [CpW-1:0] SurrLast  = 21'h00DFFF;

    // Byte counts reported with a result.
    localparam logic [UsedW-1:0] Used1 = 3'd1;
    localparam logic [UsedW-1:0] Used2 = 3'd2;
    localparam logic [UsedW-1:0] Used3 = 3'd3;
    localparam logic [UsedW-1:0] Used4 = 3'd4;
    localparam logic [UsedW-1:0] Used5 = 3'd5;
    localparam logic [UsedW-1:0] Used6 = 3'd6;

    // Number of bytes of the pending sequence already taken.
    typedef enum logic [2:0] {
        POS_IDLE  = 3'd0,
        POS_ONE   = 3'd1,
        POS_TWO   = 3'd2,
        POS_THREE = 3'd3,
        POS_FOUR  = 3'd4,
        POS_FIVE  = 3'd5
    } t_pos;

    function automatic logic is_cont(input logic [ByteW-1:0] b);
        return b[7:6] == ContPfx;
    endfunction

endpackage

### design/cesu8_byte_decoder.sv
// A byte accepted into the input register is decoded and its result is captured in the result register.
// Throughput: one byte per cycle unless a result is stalled in the result slot; the decode step sits between the input
// register and the result register, and the result register holds under stall.
// A byte that only extends a pending sequence produces no result transaction.
// Reset (synchronous, active low) empties both registers and clears the
// pending sequence.
module cesu8_byte_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [cesu8_pkg::ByteW-1:0]       i_in_byte,
    input  logic                              i_end_of_buffer,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cesu8_pkg::CpW-1:0]         o_code_point,
    output logic                              o_bad,
    output logic [cesu8_pkg::UsedW-1:0]       o_bytes_used
);

    // Input register.
    logic                        r_in_valid;
    logic [cesu8_pkg::ByteW-1:0] r_byte;
    logic                        r_last;

    // Decoder state.
    cesu8_pkg::t_pos             r_pos, n_pos;
    logic [cesu8_pkg::ByteW-1:0] r_lead, r_second, r_third, r_fifth;

    // Result register.
    logic                        r_out_valid;
    logic [cesu8_pkg::CpW-1:0]   r_cp;
    logic                        r_bad;
    logic [cesu8_pkg::UsedW-1:0] r_used;

    // Decode outputs.
    logic                        emit;
    logic                        res_bad;
    logic [cesu8_pkg::CpW-1:0]   res_cp;
    logic [cesu8_pkg::UsedW-1:0] res_used;
    logic [cesu8_pkg::CpW-1:0]   pair_cp;
    logic                        consume;

    // The registered byte moves on when it emits nothing or the result slot is free.
    assign consume    = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || consume;

    // Surrogate pair value, built from the stored bytes and the final one.
    assign pair_cp = {1'b0, r_second[3:0], r_third[5:0], r_fifth[3:0], r_byte[5:0]}
                     + cesu8_pkg::SuppBase;

    // Next position: any result closes the sequence, otherwise one more byte is taken.
    always_comb begin
        n_pos = r_pos;
        if (emit) begin
            n_pos = cesu8_pkg::POS_IDLE;
        end else begin
            case (r_pos)
                cesu8_pkg::POS_IDLE:  n_pos = cesu8_pkg::POS_ONE;
                cesu8_pkg::POS_ONE:   n_pos = cesu8_pkg::POS_TWO;
                cesu8_pkg::POS_TWO:   n_pos = cesu8_pkg::POS_THREE;
                cesu8_pkg::POS_THREE: n_pos = cesu8_pkg::POS_FOUR;
                cesu8_pkg::POS_FOUR:  n_pos = cesu8_pkg::POS_FIVE;
                default:              n_pos = cesu8_pkg::POS_IDLE;
            endcase
        end
    end

    // Result decision for the registered byte at the current position.
    always_comb begin
        emit     = 1'b0;
        res_bad  = 1'b0;
        res_cp   = '0;
        res_used = cesu8_pkg::Used1;
        case (r_pos)
            cesu8_pkg::POS_ONE: begin
                res_used = cesu8_pkg::Used2;
                if (r_lead[7:5] == cesu8_pkg::TwoBytePfx) begin
                    emit    = 1'b1;
                    res_bad = !cesu8_pkg::is_cont(r_byte);
                    res_cp  = {10'd0, r_lead[4:0], r_byte[5:0]};
                end else if (r_last) begin
                    emit    = 1'b1;
                    res_bad = 1'b1;
                end
            end
            cesu8_pkg::POS_TWO: begin
                res_used = cesu8_pkg::Used3;
                if (r_lead == cesu8_pkg::SurrLead &&
                    r_second[7:4] == cesu8_pkg::SurrHiNib) begin
                    if (!cesu8_pkg::is_cont(r_byte) || r_last) begin
                        emit    = 1'b1;
                        res_bad = 1'b1;
                    end
                end else begin
                    emit    = 1'b1;
                    res_bad = !cesu8_pkg::is_cont(r_second) || !cesu8_pkg::is_cont(r_byte);
                    res_cp  = {5'd0, r_lead[3:0], r_second[5:0], r_byte[5:0]};
                end
            end
            cesu8_pkg::POS_THREE: begin
                res_used = cesu8_pkg::Used4;
                if (r_byte != cesu8_pkg::SurrLead || r_last) begin
                    emit    = 1'b1;
                    res_bad = 1'b1;
                end
            end
            cesu8_pkg::POS_FOUR: begin
                res_used = cesu8_pkg::Used5;
                if (r_byte[7:4] != cesu8_pkg::SurrLoNib || r_last) begin
                    emit    = 1'b1;
                    res_bad = 1'b1;
                end
            end
            cesu8_pkg::POS_FIVE: begin
                res_used = cesu8_pkg::Used6;
                emit     = 1'b1;
                res_cp   = pair_cp;
                res_bad  = !cesu8_pkg::is_cont(r_byte) || pair_cp > cesu8_pkg::CpMax ||
                           (pair_cp inside {[cesu8_pkg::SurrFirst:cesu8_pkg::SurrLast]});
            end
            default: begin
                // No sequence pending: ASCII completes, a flagged last lead is bad.
                res_used = cesu8_pkg::Used1;
                if (!r_byte[7]) begin
                    emit   = 1'b1;
                    res_cp = {13'd0, r_byte};
                end else if (r_last) begin
                    emit    = 1'b1;
                    res_bad = 1'b1;
                end
            end
        endcase
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_in_byte;
            r_last <= i_end_of_buffer;
        end
    end

    // Decoder position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= cesu8_pkg::POS_IDLE;
        end else if (consume) begin
            r_pos <= n_pos;
        end
    end

    // Bytes kept for later steps of a sequence.
    always_ff @(posedge i_clk) begin
        if (consume && !emit) begin
            case (r_pos)
                cesu8_pkg::POS_IDLE: r_lead   <= r_byte;
                cesu8_pkg::POS_ONE:  r_second <= r_byte;
                cesu8_pkg::POS_TWO:  r_third  <= r_byte;
                cesu8_pkg::POS_FOUR: r_fifth  <= r_byte;
                default: ;
            endcase
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload; a bad character carries a zero code point.
    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_cp   <= res_bad ? '0 : res_cp;
            r_bad  <= res_bad;
            r_used <= res_used;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_cp;
    assign o_bad        = r_bad;
    assign o_bytes_used = r_used;

    // A bad result never carries a code point.
    a_bad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_bad |-> r_cp == '0)
        else $error("bad result with nonzero code point");

    // A good result is within the Unicode range.
    a_cp_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_bad |-> r_cp <= cesu8_pkg::CpMax)
        else $error("code point above range");

    // The byte count of a result is 1 to 6.
    a_used_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_used >= cesu8_pkg::Used1 && r_used <= cesu8_pkg::Used6)
        else $error("byte count out of range");

    // A stalled result is neither dropped nor overwritten.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_used) && $stable(r_cp))
        else $error("stalled result changed");

    // Input stalls only while a registered byte waits for the result slot.
    a_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && emit && r_out_valid && !i_out_ready)
        else $error("input stalled without cause");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Field widths taken from the package.
    localparam int unsigned ByteW = cesu8_pkg::ByteW;
    localparam int unsigned CpW   = cesu8_pkg::CpW;
    localparam int unsigned UsedW = cesu8_pkg::UsedW;

    // Run length and the long receiver hold-offs that back the block up.
    localparam int unsigned RandomItems = 1750;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned HoldLen     = 64;
    localparam int unsigned HoldStartA  = 300;
    localparam int unsigned HoldStartB  = 2000;

    // One input byte and one decoded character.
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } t_byte_item;

    typedef struct packed {
        logic [CpW-1:0]   cp;
        logic             bad;
        logic [UsedW-1:0] used;
    } t_char_result;

    // Shapes of the random character sequences.
    typedef enum int {
        GEN_ASCII,
        GEN_TWO,
        GEN_THREE,
        GEN_PAIR,
        GEN_ODD_LEAD,
        GEN_NOISE
    } t_gen_kind;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_in_valid      = 1'b0;
    logic [ByteW-1:0] i_in_byte       = '0;
    logic             i_end_of_buffer = 1'b0;
    logic             i_out_ready     = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [CpW-1:0]   o_code_point;
    logic             o_bad;
    logic [UsedW-1:0] o_bytes_used;

    t_byte_item   byte_q[$];
    t_char_result char_expect_q[$];

    // Decoder state as the byte stream has left it.
    cesu8_pkg::t_pos  dec_pos    = cesu8_pkg::POS_IDLE;
    logic [ByteW-1:0] dec_lead   = '0;
    logic [ByteW-1:0] dec_second = '0;
    logic [ByteW-1:0] dec_third  = '0;
    logic [ByteW-1:0] dec_fifth  = '0;

    int  errors    = 0;
    int  cycle_cnt = 0;
    int  tx_wait   = 0;
    int  rx_wait   = 0;
    bit  tx_burst  = 1'b0;
    bit  rx_burst  = 1'b0;
    bit  rx_hold   = 1'b0;

    cesu8_byte_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_buffer(i_end_of_buffer),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_code_point   (o_code_point),
        .o_bad          (o_bad),
        .o_bytes_used   (o_bytes_used)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    // Advance the decoder by one byte and queue the character it completes, if any.
    task automatic predict_char(input logic [ByteW-1:0] b, input logic last);
        t_char_result   res;
        logic [CpW-1:0] pair_cp;
        logic           emit;
        res = '0;
        emit = 1'b1;
        pair_cp = '0;
        case (dec_pos)
            cesu8_pkg::POS_ONE: begin
                res.used = cesu8_pkg::Used2;
                if (dec_lead[7:5] == cesu8_pkg::TwoBytePfx) begin
                    if (b[7:6] == cesu8_pkg::ContPfx) begin
                        res.cp = CpW'({dec_lead[4:0], b[5:0]});
                    end else begin
                        res.bad = 1'b1;
                    end
                end else if (last) begin
                    res.bad = 1'b1;
                end else begin
                    dec_second = b;
                    dec_pos = cesu8_pkg::POS_TWO;
                    emit = 1'b0;
                end
            end
            cesu8_pkg::POS_TWO: begin
                res.used = cesu8_pkg::Used3;
                if (dec_lead == cesu8_pkg::SurrLead &&
                    dec_second[7:4] == cesu8_pkg::SurrHiNib) begin
                    if (b[7:6] != cesu8_pkg::ContPfx || last) begin
                        res.bad = 1'b1;
                    end else begin
                        dec_third = b;
                        dec_pos = cesu8_pkg::POS_THREE;
                        emit = 1'b0;
                    end
                end else if (dec_second[7:6] == cesu8_pkg::ContPfx &&
                             b[7:6] == cesu8_pkg::ContPfx) begin
                    // Any lead that is not a two-byte lead lands here; only its low nibble counts.
                    res.cp = CpW'({dec_lead[3:0], dec_second[5:0], b[5:0]});
                end else begin
                    res.bad = 1'b1;
                end
            end
            cesu8_pkg::POS_THREE: begin
                res.used = cesu8_pkg::Used4;
                if (b != cesu8_pkg::SurrLead || last) begin
                    res.bad = 1'b1;
                end else begin
                    dec_pos = cesu8_pkg::POS_FOUR;
                    emit = 1'b0;
                end
            end
            cesu8_pkg::POS_FOUR: begin
                res.used = cesu8_pkg::Used5;
                if (b[7:4] != cesu8_pkg::SurrLoNib || last) begin
                    res.bad = 1'b1;
                end else begin
                    dec_fifth = b;
                    dec_pos = cesu8_pkg::POS_FIVE;
                    emit = 1'b0;
                end
            end
            cesu8_pkg::POS_FIVE: begin
                res.used = cesu8_pkg::Used6;
                pair_cp = CpW'({dec_second[3:0], dec_third[5:0], dec_fifth[3:0], b[5:0]})
                          + cesu8_pkg::SuppBase;
                if (b[7:6] == cesu8_pkg::ContPfx && pair_cp <= cesu8_pkg::CpMax &&
                    (pair_cp < cesu8_pkg::SurrFirst || pair_cp > cesu8_pkg::SurrLast)) begin
                    res.cp = pair_cp;
                end else begin
                    res.bad = 1'b1;
                end
            end
            default: begin
                res.used = cesu8_pkg::Used1;
                if (!b[7]) begin
                    res.cp = CpW'(b);
                end else if (last) begin
                    res.bad = 1'b1;
                end else begin
                    dec_lead = b;
                    dec_pos = cesu8_pkg::POS_ONE;
                    emit = 1'b0;
                end
            end
        endcase
        if (emit) begin
            dec_pos = cesu8_pkg::POS_IDLE;
            char_expect_q.push_back(res);
        end
    endtask

    task automatic add_byte(input logic [ByteW-1:0] b, input logic last);
        byte_q.push_back('{data: b, last: last});
    endtask

    // One random character: mostly well formed, sometimes corrupted or cut short.
    task automatic add_random_char();
        logic [ByteW-1:0] seq [6];
        logic [31:0]      rnd;
        t_gen_kind        kind;
        int               pick;
        int               n;
        rnd = $urandom;
        pick = $urandom_range(0, 9);
        n = 1;
        if (pick < 2) kind = GEN_ASCII;
        else if (pick < 3) kind = GEN_TWO;
        else if (pick < 5) kind = GEN_THREE;
        else if (pick < 7) kind = GEN_PAIR;
        else if (pick < 8) kind = GEN_ODD_LEAD;
        else kind = GEN_NOISE;
        case (kind)
            GEN_ASCII: begin
                seq[0] = {1'b0, rnd[6:0]};
            end
            GEN_TWO: begin
                seq[0] = {3'b110, rnd[4:0]};
                seq[1] = {2'b10, rnd[10:5]};
                n = 2;
            end
            GEN_THREE, GEN_ODD_LEAD: begin
                if (kind == GEN_THREE) seq[0] = {4'b1110, rnd[3:0]};
                else if (rnd[31]) seq[0] = {2'b10, rnd[5:0]};
                else seq[0] = {4'b1111, rnd[3:0]};
                seq[1] = {2'b10, rnd[11:6]};
                seq[2] = {2'b10, rnd[17:12]};
                n = 3;
            end
            GEN_PAIR: begin
                seq[0] = cesu8_pkg::SurrLead;
                seq[1] = {cesu8_pkg::SurrHiNib, rnd[3:0]};
                seq[2] = {2'b10, rnd[9:4]};
                seq[3] = cesu8_pkg::SurrLead;
                seq[4] = {cesu8_pkg::SurrLoNib, rnd[13:10]};
                seq[5] = {2'b10, rnd[19:14]};
                n = 6;
            end
            default: begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) seq[i] = ByteW'($urandom);
            end
        endcase
        // Break one byte of some sequences.
        if ($urandom_range(0, 7) == 0) seq[$urandom_range(0, n - 1)] = ByteW'($urandom);
        for (int i = 0; i < n; i++) begin
            if (kind == GEN_NOISE) add_byte(seq[i], $urandom_range(0, 3) == 0);
            else add_byte(seq[i], $urandom_range(0, 15) == 0);
        end
    endtask

    // Directed bytes: field extremes, each form, and each way a sequence can go bad.
    task automatic load_directed();
        // ASCII extremes; the end flag is harmless on a complete character.
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b1);
        // Largest two-byte character, completed on a byte flagged as last.
        add_byte(8'hDF, 1'b0);
        add_byte(8'hBF, 1'b1);
        // Two-byte form with a bad continuation.
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b0);
        // Three-byte form, bad middle byte found only at the third byte.
        add_byte(8'hE2, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h80, 1'b0);
        // Largest surrogate pair.
        add_byte(8'hED, 1'b0);
        add_byte(8'hAF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hED, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        // Surrogate pair whose third byte is not a continuation.
        add_byte(8'hED, 1'b0);
        add_byte(8'hA5, 1'b0);
        add_byte(8'h41, 1'b0);
        // Surrogate pair whose fifth byte is outside B0..BF.
        add_byte(8'hED, 1'b0);
        add_byte(8'hA0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hED, 1'b0);
        add_byte(8'h41, 1'b0);
        // Odd lead cut short by the end of the buffer, then a lone continuation as last.
        add_byte(8'hF8, 1'b0);
        add_byte(8'h80, 1'b1);
        add_byte(8'h80, 1'b1);
    endtask

    // Byte driver: one transaction per queued item, with random gaps.
    always @(posedge i_clk) begin : drive_bytes
        t_byte_item item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_char(i_in_byte, i_end_of_buffer);
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_wait != 0) begin
                    tx_wait <= tx_wait - 1;
                    i_in_valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    item = byte_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_byte <= item.data;
                    i_end_of_buffer <= item.last;
                    tx_wait <= draw_wait(tx_burst);
                    if ($urandom_range(0, 63) == 0) tx_burst <= !tx_burst;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Character monitor: compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin : check_chars
        t_char_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (char_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected character: expected none, got cp=%h bad=%b used=%0d",
                             $time, o_code_point, o_bad, o_bytes_used);
                end else begin
                    want = char_expect_q.pop_front();
                    if (o_code_point !== want.cp) begin
                        errors++;
                        $display("%0t: code_point expected %h, got %h",
                                 $time, want.cp, o_code_point);
                    end
                    if (o_bad !== want.bad) begin
                        errors++;
                        $display("%0t: bad expected %b, got %b", $time, want.bad, o_bad);
                    end
                    if (o_bytes_used !== want.used) begin
                        errors++;
                        $display("%0t: bytes_used expected %0d, got %0d",
                                 $time, want.used, o_bytes_used);
                    end
                end
                rx_wait = draw_wait(rx_burst);
                if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
            end
            if (rx_hold) begin
                i_out_ready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Cycle count, long receiver hold-offs, and the run timeout.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        rx_hold <= (cycle_cnt >= HoldStartA && cycle_cnt < HoldStartA + HoldLen) ||
                   (cycle_cnt >= HoldStartB && cycle_cnt < HoldStartB + HoldLen);
        if (cycle_cnt == CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : run_test
        int target;
        load_directed();
        target = byte_q.size() + RandomItems;
        while (byte_q.size() < target) add_random_char();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to be taken and every character to come back.
        while (byte_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (char_expect_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
